>>> rtl/core/forth_data_stack_unit_macros.svh
`ifndef FORTH_DATA_STACK_UNIT_MACROS_SVH
`define FORTH_DATA_STACK_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define FDSU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdsu implication check failed");

// invariant checked on every clock edge outside reset
`define FDSU_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("fdsu invariant check failed");

`endif

>>> rtl/core/fdsu_pkg.sv
`timescale 1ns / 1ps

package fdsu_pkg;

	localparam int STACK_ENTRIES  = 256;
	localparam int VARIABLE_COUNT = 64;

	localparam int IDX_W = $clog2(STACK_ENTRIES);
	localparam int SP_W  = $clog2(STACK_ENTRIES + 1);
	localparam int VAR_W = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

	typedef enum logic [3:0] {
		OP_PUSH    = 4'd0,
		OP_DEPTH   = 4'd1,
		OP_POP     = 4'd2,
		OP_NOT     = 4'd3,
		OP_DUP     = 4'd4,
		OP_OVER    = 4'd5,
		OP_SWAP    = 4'd6,
		OP_ROT     = 4'd7,
		OP_PICK    = 4'd8,
		OP_PUT     = 4'd9,
		OP_ROTATE  = 4'd10,
		OP_FETCH   = 4'd11,
		OP_STORE   = 4'd12,
		OP_VARCHK  = 4'd13,
		OP_AND     = 4'd14,
		OP_OR      = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_COUNT = 3'd3,
		ST_VAR   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PROBE,
		S_FETCH,
		S_POP2,
		S_POP1,
		S_ROTN,
		S_DONE
	} state_t;

	// per-cell move selected by the sequencer
	typedef enum logic [2:0] {
		C_HOLD,
		C_DOWN,   // cell 0 takes din, cells 1..arg take their upper neighbor
		C_UP,     // cells below arg take their lower neighbor, cell arg takes din
		C_ROTP,   // cell 0 takes din, cells from arg on take their lower neighbor
		C_WRITE   // cell arg takes din
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t        kind;
		logic [31:0]       din;
		logic [IDX_W-1:0]  arg;
		logic              probe_load;
		logic              probe_shift;
	} cell_ctl_t;

endpackage

>>> rtl/core/fdsu_ram.sv
`timescale 1ns / 1ps

module fdsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/fdsu_cell.sv
`timescale 1ns / 1ps

module fdsu_cell import fdsu_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [31:0]      upper_val,   // cell nearer the top
	input  logic [31:0]      lower_val,   // cell deeper in the stack
	input  logic [31:0]      lower_probe,
	output logic [31:0]      val,
	output logic [31:0]      probe
);

	logic [31:0] val_q;
	logic [31:0] probe_q;
	logic [31:0] val_d;

	always_comb begin
		val_d = val_q;
		unique case (ctl.kind)
			C_HOLD: val_d = val_q;
			C_DOWN: begin
				if (idx == '0) val_d = ctl.din;
				else if (idx <= ctl.arg) val_d = upper_val;
			end
			C_UP: begin
				if (idx < ctl.arg) val_d = lower_val;
				else if (idx == ctl.arg) val_d = ctl.din;
			end
			C_ROTP: begin
				if (idx == '0) val_d = ctl.din;
				else if (idx >= ctl.arg) val_d = lower_val;
			end
			C_WRITE: begin
				if (idx == ctl.arg) val_d = ctl.din;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (ctl.probe_load) begin
			probe_q <= val_q;
		end else if (ctl.probe_shift) begin
			probe_q <= lower_probe;
		end
	end

	assign val   = val_q;
	assign probe = probe_q;

endmodule

>>> rtl/core/forth_data_stack_unit.sv
`timescale 1ns / 1ps
// Data stack of 32-bit signed entries held in a row of cells, cell 0 being the
// top; every item carries one opcode and returns status, top value and depth.
// Fetch reads the variable RAM before writing the top; and/or, put and store
// write first and then drop entries from the top; a negative rotate drops the
// count and then moves the new top deeper. Pick and positive rotate bring the
// n-th entry to the top by shifting a probe register along the cell row one
// cell per cycle. The variable file is a RAM with registered read and per-entry
// valid bits, so it reads as zero until written. A finished result waits in the
// output register while the next item is taken.

`include "forth_data_stack_unit_macros.svh"

module forth_data_stack_unit import fdsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[3:0], literal[35:4], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[2:0], top_value[34:3], stack_depth[43:35], zero pad
);

	state_t            state_q, state_d;
	opcode_t           op_q;
	logic [31:0]       lit_q;
	status_t           status_q, status_d;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic [IDX_W-1:0]  arg_q, arg_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              fetch_vld_q, fetch_vld_d;
	logic [VARIABLE_COUNT-1:0] var_vld_q;

	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [31:0]       out_top_q;
	logic [8:0]        out_depth_q;

	cell_ctl_t         ctl;
	logic [31:0]       cval   [STACK_ENTRIES];
	logic [31:0]       cprobe [STACK_ENTRIES];

	logic              ram_we;
	logic [VAR_W-1:0]  ram_addr;
	logic [31:0]       ram_rdata;

	logic              accept, out_free, out_load;
	logic [31:0]       c0, c1, c2;
	logic [1:0]        need;
	logic              grow;
	logic signed [32:0] n33, d33, neg33;
	logic              var_ok;

	assign c0 = cval[0];
	assign c1 = cval[1];
	assign c2 = cval[2];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) || (state_q == S_DONE && out_free);
	assign accept   = s_tvalid && s_tready;

	assign n33      = $signed({c0[31], c0});
	assign d33      = $signed(33'(sp_q)) - 33'sd1;
	assign neg33    = -n33;
	assign var_ok   = !c0[31] && (c0 < 32'(VARIABLE_COUNT));
	assign ram_addr = c0[VAR_W-1:0];

	always_comb begin
		need = 2'd1;
		grow = 1'b0;
		unique case (op_q)
			OP_PUSH, OP_DEPTH: begin
				need = 2'd0;
				grow = 1'b1;
			end
			OP_DUP: grow = 1'b1;
			OP_OVER: begin
				need = 2'd2;
				grow = 1'b1;
			end
			OP_SWAP, OP_STORE, OP_AND, OP_OR: need = 2'd2;
			OP_ROT: need = 2'd3;
			default: need = 2'd1;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		sp_d        = sp_q;
		arg_d       = arg_q;
		cnt_d       = cnt_q;
		fetch_vld_d = fetch_vld_q;
		ram_we      = 1'b0;
		out_load    = 1'b0;
		ctl         = '{kind: C_HOLD, din: '0, arg: '0, probe_load: 1'b0, probe_shift: 1'b0};

		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d  = S_DONE;
				status_d = ST_OK;
				if (sp_q < SP_W'(need)) begin
					status_d = ST_UNDER;
				end else if (grow && sp_q == SP_W'(STACK_ENTRIES)) begin
					status_d = ST_OVER;
				end else begin
					unique case (op_q)
						OP_PUSH, OP_DEPTH, OP_DUP, OP_OVER: begin
							ctl.kind = C_DOWN;
							ctl.arg  = IDX_W'(STACK_ENTRIES - 1);
							unique case (op_q)
								OP_PUSH:  ctl.din = lit_q;
								OP_DEPTH: ctl.din = 32'(sp_q);
								OP_DUP:   ctl.din = c0;
								default:  ctl.din = c1;
							endcase
							sp_d = sp_q + SP_W'(1);
						end
						OP_POP: begin
							ctl.kind = C_UP;
							ctl.arg  = IDX_W'(STACK_ENTRIES - 1);
							sp_d     = sp_q - SP_W'(1);
						end
						OP_NOT: begin
							ctl.kind = C_WRITE;
							ctl.din  = {31'd0, c0 == 32'd0};
						end
						OP_SWAP: begin
							ctl.kind = C_DOWN;
							ctl.arg  = IDX_W'(1);
							ctl.din  = c1;
						end
						OP_ROT: begin
							ctl.kind = C_DOWN;
							ctl.arg  = IDX_W'(2);
							ctl.din  = c2;
						end
						OP_PICK: begin
							if (n33 < 33'sd1 || n33 > d33) begin
								status_d = ST_COUNT;
							end else begin
								ctl.probe_load = 1'b1;
								cnt_d   = n33[IDX_W-1:0];
								state_d = S_PROBE;
							end
						end
						OP_PUT: begin
							if (n33 < 33'sd1 || n33 >= d33) begin
								status_d = ST_COUNT;
							end else begin
								ctl.kind = C_WRITE;
								ctl.arg  = n33[IDX_W-1:0] + IDX_W'(1);
								ctl.din  = c1;
								state_d  = S_POP2;
							end
						end
						OP_ROTATE: begin
							if (n33 > d33 || neg33 > d33) begin
								status_d = ST_COUNT;
							end else if (n33 > 33'sd0) begin
								ctl.probe_load = 1'b1;
								cnt_d   = n33[IDX_W-1:0];
								arg_d   = n33[IDX_W-1:0];
								state_d = S_PROBE;
							end else begin
								ctl.kind = C_UP;
								ctl.arg  = IDX_W'(STACK_ENTRIES - 1);
								sp_d     = sp_q - SP_W'(1);
								if (n33 < 33'sd0) begin
									arg_d   = neg33[IDX_W-1:0] - IDX_W'(1);
									state_d = S_ROTN;
								end
							end
						end
						OP_FETCH: begin
							if (!var_ok) begin
								status_d = ST_VAR;
							end else begin
								fetch_vld_d = var_vld_q[ram_addr];
								state_d     = S_FETCH;
							end
						end
						OP_STORE: begin
							if (!var_ok) begin
								status_d = ST_VAR;
							end else begin
								ram_we  = 1'b1;
								state_d = S_POP2;
							end
						end
						OP_VARCHK: begin
							if (!var_ok) status_d = ST_VAR;
						end
						default: begin
							// and / or: result goes to the second entry, then the top drops
							ctl.kind = C_WRITE;
							ctl.arg  = IDX_W'(1);
							ctl.din  = (op_q == OP_AND) ? {31'd0, (c1 != '0) && (c0 != '0)}
								: {31'd0, (c1 != '0) || (c0 != '0)};
							state_d  = S_POP1;
						end
					endcase
				end
			end
			S_PROBE: begin
				if (cnt_q != '0) begin
					ctl.probe_shift = 1'b1;
					cnt_d = cnt_q - IDX_W'(1);
				end else if (op_q == OP_PICK) begin
					ctl.kind = C_WRITE;
					ctl.din  = cprobe[0];
					state_d  = S_DONE;
				end else begin
					ctl.kind = C_ROTP;
					ctl.arg  = arg_q;
					ctl.din  = cprobe[0];
					sp_d     = sp_q - SP_W'(1);
					state_d  = S_DONE;
				end
			end
			S_FETCH: begin
				ctl.kind = C_WRITE;
				ctl.din  = fetch_vld_q ? ram_rdata : 32'd0;
				state_d  = S_DONE;
			end
			S_POP2, S_POP1: begin
				ctl.kind = C_UP;
				ctl.arg  = IDX_W'(STACK_ENTRIES - 1);
				sp_d     = sp_q - SP_W'(1);
				state_d  = (state_q == S_POP2) ? S_POP1 : S_DONE;
			end
			S_ROTN: begin
				ctl.kind = C_UP;
				ctl.arg  = arg_q;
				ctl.din  = c0;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = accept ? S_EXEC : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			var_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			if (ram_we) var_vld_q[ram_addr] <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(s_tdata[3:0]);
			lit_q <= s_tdata[35:4];
		end
		status_q    <= status_d;
		arg_q       <= arg_d;
		cnt_q       <= cnt_d;
		fetch_vld_q <= fetch_vld_d;
		if (out_load) begin
			out_status_q <= status_q;
			out_top_q    <= (sp_q != '0) ? c0 : 32'd0;
			out_depth_q  <= 9'(sp_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_depth_q, out_top_q, out_status_q};

	fdsu_ram #(
		.WIDTH (32),
		.DEPTH (VARIABLE_COUNT)
	) u_var_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (c1),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	for (genvar k = 0; k < STACK_ENTRIES; k++) begin : g_cell
		fdsu_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.idx         (IDX_W'(k)),
			.upper_val   ((k == 0) ? 32'd0 : cval[(k == 0) ? 0 : k - 1]),
			.lower_val   ((k == STACK_ENTRIES - 1) ? 32'd0
				: cval[(k == STACK_ENTRIES - 1) ? k : k + 1]),
			.lower_probe ((k == STACK_ENTRIES - 1) ? 32'd0
				: cprobe[(k == STACK_ENTRIES - 1) ? k : k + 1]),
			.val         (cval[k]),
			.probe       (cprobe[k])
		);
	end

	`FDSU_ASSERT_ALWAYS(a_sp_bound, sp_q <= SP_W'(STACK_ENTRIES))
	`FDSU_ASSERT_IMPL(a_err_keeps_depth, state_q == S_DONE && status_q != ST_OK, $stable(sp_q))
	`FDSU_ASSERT_IMPL(a_probe_op, state_q == S_PROBE, op_q == OP_PICK || op_q == OP_ROTATE)
	`FDSU_ASSERT_IMPL(a_no_accept_busy, accept, state_q == S_IDLE || state_q == S_DONE)

endmodule
